>>> design/gps_haversine_odometer_macros.svh
// ----------------------------------------------------------------------------
// gps haversine odometer assertion macros
// concurrent checks sampled on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef GPS_HAVERSINE_ODOMETER_MACROS_SVH
`define GPS_HAVERSINE_ODOMETER_MACROS_SVH

// same-cycle implication
`define GHO_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("gho check failed");

// next-cycle implication
`define GHO_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("gho check failed");

`endif

>>> design/gho_pkg.sv
// ----------------------------------------------------------------------------
// gho_pkg
// shared widths, constants, codes, state types and the cordic angle table
// ----------------------------------------------------------------------------
package gho_pkg;

	localparam int MAX_POINTS   = 1000;
	localparam int CORDIC_STEPS = 24;

	localparam int LAT_W     = 28;
	localparam int LON_W     = 29;
	localparam int CNT_W     = 10;
	localparam int TOT_W     = 40;
	localparam int CFG_W     = 24;
	localparam int WARM_W    = 10;
	localparam int RES_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam int CW       = 36;
	localparam int ZW       = 35;
	localparam int MW       = 34;
	localparam int PW       = 2 * MW;
	localparam int NUM_W    = 40;
	localparam int SQ_W     = 63;
	localparam int SQ_STEPS = 32;
	localparam int DW       = 34;
	localparam int CTR_W    = 6;
	localparam int MUL_LAST = 7;
	localparam int DEG_DIV  = 45;
	localparam int NUM_BIAS = 22;

	// divide by 45 one byte per cycle: 2^20 / 45 rounded up
	localparam int DIG_W      = 8;
	localparam int DIV_DIGITS = 5;
	localparam int DIV_SHIFT  = 20;
	localparam int DIV_RECIP  = 23302;

	localparam logic signed [CW-1:0] INV_GAIN   = 36'sd652032874;
	localparam logic signed [ZW-1:0] Q30_Z      = 35'sd1073741824;
	localparam logic signed [ZW-1:0] Q31_Z      = 35'sd2147483648;
	localparam logic signed [MW-1:0] Q30_M      = 34'sd1073741824;
	localparam logic [30:0]          Q30_A      = 31'd1073741824;
	localparam logic signed [MW-1:0] DIST_SCALE = 34'sd2561931110;
	localparam logic [PW-1:0]        ROUND_HALF = 68'd268435456;
	localparam logic [SQ_W-1:0]      SBIT_INIT  = {1'b1, {(SQ_W-1){1'b0}}};
	localparam logic [TOT_W-1:0]     TOTAL_MAX  = {TOT_W{1'b1}};

	localparam logic [RES_W-1:0] RES_NONE = 3'd0;
	localparam logic [RES_W-1:0] RES_WARM = 3'd1;
	localparam logic [RES_W-1:0] RES_ADD  = 3'd2;
	localparam logic [RES_W-1:0] RES_REJ  = 3'd3;
	localparam logic [RES_W-1:0] RES_FULL = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WARM = 2'd2;

	localparam logic [CFG_W-1:0]  MIN_RST  = 24'd256;
	localparam logic [CFG_W-1:0]  MAX_RST  = 24'd1280000;
	localparam logic [WARM_W-1:0] WARM_RST = 10'd5;

	typedef enum logic [1:0] {
		T_IDLE,
		T_CHK,
		T_DIST,
		T_FIN
	} top_state_t;

	typedef enum logic [3:0] {
		D_IDLE,
		D_LOAD,
		D_DIV,
		D_RINIT,
		D_ROT,
		D_RSTORE,
		D_MUL,
		D_SQRT,
		D_VEC,
		D_SCALE,
		D_ROUND
	} dist_state_t;

	typedef struct packed {
		logic                    start;
		logic signed [LAT_W-1:0] lat1;
		logic signed [LON_W-1:0] lon1;
		logic signed [LAT_W-1:0] lat0;
		logic signed [LON_W-1:0] lon0;
	} dist_req_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] step;
	} dist_rsp_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

>>> design/gps_haversine_odometer.sv
// ----------------------------------------------------------------------------
// gps_haversine_odometer
// recording-mode odometer: counts fixes, sums haversine steps between
// accepted points into a saturating total
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    fix_valid, latitude, longitude, button
//  out      out_valid/out_ready  recording, fix_result, point_count, total_distance
//  cfg      cfg_we               cfg_index, cfg_data
//
//  a word with no distance step goes from accept through T_CHK and T_FIN to its result
//  for a word with a distance step the time from accept to result is set by
//  the shared cordic stage (four rotations and one vectoring pass), the
//  divide-by-45 byte loop and the square root pair loop
//  in_ready is high only while no word is in flight
//  a result waits in the output register while out_ready is low
//  reset clears mode, count, total and last point and restores the default configuration
// ----------------------------------------------------------------------------
`include "gps_haversine_odometer_macros.svh"

module gps_haversine_odometer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 fix_valid,
	input  logic signed [gho_pkg::LAT_W-1:0]     latitude,
	input  logic signed [gho_pkg::LON_W-1:0]     longitude,
	input  logic                                 button,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 recording,
	output logic [gho_pkg::RES_W-1:0]            fix_result,
	output logic [gho_pkg::CNT_W-1:0]            point_count,
	output logic [gho_pkg::TOT_W-1:0]            total_distance,
	input  logic                                 cfg_we,
	input  logic [gho_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gho_pkg::CFG_W-1:0]            cfg_data
);
	import gho_pkg::*;

	top_state_t state_q, state_d;

	logic [CFG_W-1:0]  min_q, max_q;
	logic [WARM_W-1:0] warm_q;

	logic                    fix_q, btn_q;
	logic signed [LAT_W-1:0] lat_q, last_lat_q;
	logic signed [LON_W-1:0] lon_q, last_lon_q;
	logic                    mode_q;
	logic [CNT_W-1:0]        count_q;
	logic [TOT_W-1:0]        total_q;

	logic             out_valid_q, rec_q;
	logic [RES_W-1:0] res_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic [TOT_W-1:0] tot_out_q;

	dist_req_t dist_req;
	dist_rsp_t dist_rsp;

	logic full, need, slot, in_range, fin;
	assign full     = count_q >= CNT_W'(MAX_POINTS);
	assign need     = mode_q && fix_q && !full &&
		(({1'b0, count_q} + 1'b1) > {1'b0, warm_q});
	assign slot     = !out_valid_q || out_ready;
	assign fin      = state_q == T_FIN && slot;
	assign in_range = dist_rsp.step > DW'(min_q) && dist_rsp.step < DW'(max_q);
	assign in_ready = state_q == T_IDLE;

	assign dist_req.start = state_q == T_CHK && need;
	assign dist_req.lat1  = lat_q;
	assign dist_req.lon1  = lon_q;
	assign dist_req.lat0  = last_lat_q;
	assign dist_req.lon0  = last_lon_q;

	gho_dist u_dist (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dist_req),
		.rsp   (dist_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE:  if (in_valid) state_d = T_CHK;
			T_CHK:   state_d = need ? T_DIST : T_FIN;
			T_DIST:  if (dist_rsp.done) state_d = T_FIN;
			T_FIN:   if (slot) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// tick outcome
	logic [TOT_W:0]    tsum;
	logic              mode_n;
	logic [RES_W-1:0]  res_n;
	logic [CNT_W-1:0]  count_n;
	logic [TOT_W-1:0]  total_n;
	logic              take;
	assign tsum = {1'b0, total_q} + (TOT_W+1)'(dist_rsp.step);

	always_comb begin
		mode_n  = mode_q;
		res_n   = RES_NONE;
		count_n = count_q;
		total_n = total_q;
		take    = 1'b0;
		if (!mode_q) begin
			mode_n = btn_q;
		end else begin
			if (fix_q) begin
				if (full) begin
					res_n = RES_FULL;
				end else if (need) begin
					if (in_range) begin
						res_n   = RES_ADD;
						total_n = tsum[TOT_W] ? TOTAL_MAX : tsum[TOT_W-1:0];
						count_n = count_q + 1'b1;
						take    = 1'b1;
					end else begin
						res_n = RES_REJ;
					end
				end else begin
					res_n   = RES_WARM;
					count_n = count_q + 1'b1;
					take    = 1'b1;
				end
			end
			if (btn_q) mode_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fix_q <= fix_valid;
			lat_q <= latitude;
			lon_q <= longitude;
			btn_q <= button;
		end
		if (fin) begin
			rec_q     <= mode_n;
			res_q     <= res_n;
			cnt_out_q <= count_n;
			tot_out_q <= total_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= MIN_RST;
			max_q       <= MAX_RST;
			warm_q      <= WARM_RST;
			mode_q      <= 1'b0;
			count_q     <= '0;
			total_q     <= '0;
			last_lat_q  <= '0;
			last_lon_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN:  min_q  <= cfg_data;
					CFG_MAX:  max_q  <= cfg_data;
					CFG_WARM: warm_q <= cfg_data[WARM_W-1:0];
					default: ;
				endcase
			end
			if (fin) begin
				mode_q  <= mode_n;
				count_q <= count_n;
				total_q <= total_n;
				if (take) begin
					last_lat_q <= lat_q;
					last_lon_q <= lon_q;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign recording      = rec_q;
	assign fix_result     = res_q;
	assign point_count    = cnt_out_q;
	assign total_distance = tot_out_q;

	`GHO_ASSERT_NOW(a_done_in_dist, dist_rsp.done, state_q == T_DIST)
	`GHO_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CNT_W'(MAX_POINTS))
	`GHO_ASSERT_NEXT(a_total_mono, 1'b1, total_q >= $past(total_q))
	`GHO_ASSERT_NOW(a_out_from_fin, $rose(out_valid_q), $past(state_q) == T_FIN)

endmodule

>>> design/gho_dist.sv
// ----------------------------------------------------------------------------
// gho_dist
// great-circle step between two fixes: divide-by-45 angle conversion,
// one shared cordic stage for sin/cos and atan, one shared multiplier,
// bit-pair square root, all sequenced one step per cycle
// ----------------------------------------------------------------------------
module gho_dist (
	input  logic              clk,
	input  logic              arst_n,
	input  gho_pkg::dist_req_t req,
	output gho_pkg::dist_rsp_t rsp
);
	import gho_pkg::*;

	dist_state_t st_q, st_d;

	logic [CTR_W-1:0] cnt_q;
	logic [1:0]       k_q;
	logic             sq_q;
	logic             flip_q;
	logic             done_q;

	logic signed [LAT_W-1:0] lat1_q, lat0_q;
	logic signed [LON_W-1:0] lon1_q, lon0_q;

	logic [NUM_W-1:0] num_q, num_sel;
	logic [31:0]      quo_q;
	logic [5:0]       rem_q;

	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [MW-1:0] sl_q, s2_q, c2_q, c0_q, m1_q, m2_q, m3_q;
	logic signed [PW-1:0] prod_q;
	logic [30:0]          a_q;
	logic [SQ_W-1:0]      sv_q, sres_q, sbit_q;
	logic [31:0]          ysq_q;
	logic [DW-1:0]        dist_q;

	logic last_div, last_cor, last_sq, last_mul;
	assign last_div = cnt_q == CTR_W'(DIV_DIGITS - 1);
	assign last_cor = cnt_q == CTR_W'(CORDIC_STEPS - 1);
	assign last_sq  = cnt_q == CTR_W'(SQ_STEPS - 1);
	assign last_mul = cnt_q == CTR_W'(MUL_LAST);

	// angle numerators
	logic [LAT_W:0]   dlat, dlat_mag;
	logic [LON_W:0]   dlon, dlon_mag;
	logic [LAT_W-1:0] lat1_mag, lat0_mag;

	assign dlat     = {lat1_q[LAT_W-1], lat1_q} - {lat0_q[LAT_W-1], lat0_q};
	assign dlon     = {lon1_q[LON_W-1], lon1_q} - {lon0_q[LON_W-1], lon0_q};
	assign dlat_mag = dlat[LAT_W] ? (~dlat + 1'b1) : dlat;
	assign dlon_mag = dlon[LON_W] ? (~dlon + 1'b1) : dlon;
	assign lat1_mag = lat1_q[LAT_W-1] ? (~lat1_q + 1'b1) : lat1_q;
	assign lat0_mag = lat0_q[LAT_W-1] ? (~lat0_q + 1'b1) : lat0_q;

	always_comb begin
		case (k_q)
			2'd0: num_sel = NUM_W'({dlat_mag, 8'b0}) + NUM_W'(NUM_BIAS);
			2'd1: num_sel = NUM_W'({dlon_mag, 8'b0}) + NUM_W'(NUM_BIAS);
			2'd2: num_sel = NUM_W'({lat1_mag, 9'b0}) + NUM_W'(NUM_BIAS);
			default: num_sel = NUM_W'({lat0_mag, 9'b0}) + NUM_W'(NUM_BIAS);
		endcase
	end

	// divide by 45, one quotient byte per cycle by reciprocal multiply
	logic [DIG_W+5:0]          trial, qm45;
	logic [DIG_W+DIV_SHIFT-1:0] qprod;
	logic [DIG_W-1:0]          qdig;
	logic [5:0]                rem_n;
	assign trial = {rem_q, num_q[NUM_W-1 -: DIG_W]};
	assign qprod = (DIG_W+DIV_SHIFT)'(trial) * (DIG_W+DIV_SHIFT)'(DIV_RECIP);
	assign qdig  = qprod[DIV_SHIFT+DIG_W-1:DIV_SHIFT];
	assign qm45  = (DIG_W+6)'(qdig) * (DIG_W+6)'(DEG_DIV);
	assign rem_n = 6'(trial - qm45);

	// fold into +-90 degrees
	logic signed [ZW-1:0] z0, zf;
	logic                 fold_hi, fold_lo;
	assign z0      = ZW'(signed'(quo_q));
	assign fold_hi = z0 > Q30_Z;
	assign fold_lo = z0 < -Q30_Z;
	assign zf      = fold_hi ? z0 - Q31_Z : (fold_lo ? z0 + Q31_Z : z0);

	// shared cordic stage
	logic [4:0]           sh;
	logic signed [CW-1:0] xs, ys, x_n, y_n;
	logic signed [ZW-1:0] at, z_n;
	logic                 neg;
	assign sh  = cnt_q[4:0];
	assign xs  = x_q >>> sh;
	assign ys  = y_q >>> sh;
	assign at  = signed'(ZW'(atan_bam(sh)));
	assign neg = (st_q == D_VEC) ? !y_q[CW-1] : z_q[ZW-1];
	assign x_n = neg ? x_q + ys : x_q - ys;
	assign y_n = neg ? y_q - xs : y_q + xs;
	assign z_n = neg ? z_q + at : z_q - at;

	logic signed [CW-1:0] s_f, c_f;
	assign s_f = flip_q ? -y_q : y_q;
	assign c_f = flip_q ? -x_q : x_q;

	// shared multiplier
	logic signed [MW-1:0] opa, opb, zc, m_sh;
	logic signed [PW-1:0] mul;
	assign zc = z_q[ZW-1] ? '0 : ((z_q > Q30_Z) ? Q30_M : z_q[MW-1:0]);

	always_comb begin
		if (st_q == D_SCALE) begin
			opa = zc;
			opb = DIST_SCALE;
		end else begin
			case (cnt_q[2:1])
				2'd0: begin opa = sl_q; opb = sl_q; end
				2'd1: begin opa = c2_q; opb = c0_q; end
				2'd2: begin opa = s2_q; opb = s2_q; end
				default: begin opa = m2_q; opb = m3_q; end
			endcase
		end
	end

	assign mul  = opa * opb;
	assign m_sh = prod_q[30+MW-1:30];

	logic signed [MW:0] asum;
	logic [30:0]        a_c;
	assign asum = {m1_q[MW-1], m1_q} + {m_sh[MW-1], m_sh};
	assign a_c  = asum[MW] ? '0 : ((asum > (MW+1)'(Q30_M)) ? Q30_A : asum[30:0]);

	// square root by bit pairs, one result bit for each pair of radicand bits
	logic [SQ_W-1:0] sq_t, sv_n, sres_n;
	logic            sq_ge;
	assign sq_t   = sres_q + sbit_q;
	assign sq_ge  = sv_q >= sq_t;
	assign sv_n   = sq_ge ? sv_q - sq_t : sv_q;
	assign sres_n = sq_ge ? (sres_q >> 1) + sbit_q : sres_q >> 1;

	logic [PW-1:0] rsum;
	assign rsum = prod_q + ROUND_HALF;

	always_comb begin
		st_d = st_q;
		case (st_q)
			D_IDLE:   if (req.start) st_d = D_LOAD;
			D_LOAD:   st_d = D_DIV;
			D_DIV:    if (last_div) st_d = D_RINIT;
			D_RINIT:  st_d = D_ROT;
			D_ROT:    if (last_cor) st_d = D_RSTORE;
			D_RSTORE: st_d = (k_q == 2'd3) ? D_MUL : D_LOAD;
			D_MUL:    if (last_mul) st_d = D_SQRT;
			D_SQRT:   if (last_sq && sq_q) st_d = D_VEC;
			D_VEC:    if (last_cor) st_d = D_SCALE;
			D_SCALE:  st_d = D_ROUND;
			D_ROUND:  st_d = D_IDLE;
			default:  st_d = D_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= st_q == D_ROUND;
			if (st_d != st_q || (st_q == D_SQRT && last_sq)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (req.start) begin
					lat1_q <= req.lat1;
					lon1_q <= req.lon1;
					lat0_q <= req.lat0;
					lon0_q <= req.lon0;
					k_q    <= 2'd0;
				end
			end
			D_LOAD: begin
				num_q <= num_sel;
				rem_q <= '0;
			end
			D_DIV: begin
				num_q <= num_q << DIG_W;
				rem_q <= rem_n;
				quo_q <= {quo_q[31-DIG_W:0], qdig};
			end
			D_RINIT: begin
				z_q    <= zf;
				flip_q <= fold_hi || fold_lo;
				x_q    <= INV_GAIN;
				y_q    <= '0;
			end
			D_ROT, D_VEC: begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
			end
			D_RSTORE: begin
				case (k_q)
					2'd0: sl_q <= s_f[MW-1:0];
					2'd1: s2_q <= s_f[MW-1:0];
					2'd2: c2_q <= c_f[MW-1:0];
					default: c0_q <= c_f[MW-1:0];
				endcase
				k_q <= k_q + 1'b1;
			end
			D_MUL: begin
				if (!cnt_q[0]) begin
					prod_q <= mul;
				end else begin
					case (cnt_q[2:1])
						2'd0: m1_q <= m_sh;
						2'd1: m2_q <= m_sh;
						2'd2: m3_q <= m_sh;
						default: begin
							a_q    <= a_c;
							sv_q   <= SQ_W'(a_c) << 30;
							sres_q <= '0;
							sbit_q <= SBIT_INIT;
							sq_q   <= 1'b0;
						end
					endcase
				end
			end
			D_SQRT: begin
				if (last_sq && !sq_q) begin
					ysq_q  <= sres_n[31:0];
					sq_q   <= 1'b1;
					sv_q   <= SQ_W'(Q30_A - a_q) << 30;
					sres_q <= '0;
					sbit_q <= SBIT_INIT;
				end else begin
					sv_q   <= sv_n;
					sres_q <= sres_n;
					sbit_q <= sbit_q >> 2;
				end
				if (last_sq && sq_q) begin
					x_q <= signed'(CW'(sres_n[31:0]));
					y_q <= signed'(CW'(ysq_q));
					z_q <= '0;
				end
			end
			D_SCALE: prod_q <= mul;
			D_ROUND: dist_q <= rsum[29+DW-1:29];
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.step = dist_q;

endmodule
